// ===== rtl/sef_pkg.sv =====
package sef_pkg;

    localparam int NUM_BITS = 32;

    localparam logic [7:0] LF_BYTE = 8'h0A;
    localparam logic [7:0] CR_BYTE = 8'h0D;
    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

    localparam logic [1:0] KIND_RETRY   = 2'd0;
    localparam logic [1:0] KIND_ID      = 2'd1;
    localparam logic [1:0] KIND_EVENT   = 2'd2;
    localparam logic [1:0] KIND_MESSAGE = 2'd3;

    localparam logic [2:0] PFX_NONE  = 3'd0;
    localparam logic [2:0] PFX_RETRY = 3'd1;
    localparam logic [2:0] PFX_ID    = 3'd2;
    localparam logic [2:0] PFX_EVENT = 3'd3;
    localparam logic [2:0] PFX_DATA  = 3'd4;

    // Prefix strings, left aligned in a 7-character field.
    localparam logic [55:0] TXT_RETRY = "retry: ";
    localparam logic [55:0] TXT_ID    = {"id: ", 24'h0};
    localparam logic [55:0] TXT_EVENT = "event: ";
    localparam logic [55:0] TXT_DATA  = {"data: ", 8'h0};

    // Output plan for one input item: prefix, digits, text byte, then LFs.
    typedef struct packed {
        logic [2:0] prefix;
        logic       digits;
        logic       send_byte;
        logic [7:0] text;
        logic [1:0] lf_cnt;
    } t_plan;

    typedef struct packed {
        logic start;
        logic take;
    } t_bcd_ctl;

    typedef struct packed {
        logic avail;
        logic last;
    } t_bcd_stat;

    function automatic logic [2:0] prefix_len(input logic [2:0] code);
        logic [2:0] len;
        unique case (code)
            PFX_RETRY: len = 3'd7;
            PFX_ID:    len = 3'd4;
            PFX_EVENT: len = 3'd7;
            PFX_DATA:  len = 3'd6;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [2:0] code, input logic [2:0] idx);
        logic [55:0] txt;
        logic [55:0] shifted;
        unique case (code)
            PFX_RETRY: txt = TXT_RETRY;
            PFX_ID:    txt = TXT_ID;
            PFX_EVENT: txt = TXT_EVENT;
            PFX_DATA:  txt = TXT_DATA;
            default:   txt = '0;
        endcase
        shifted = txt << {idx, 3'b000};
        return shifted[55:48];
    endfunction

endpackage

// ===== rtl/sef_bcd_unit.sv =====
module sef_bcd_unit #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sef_pkg::t_bcd_ctl   i_ctl,
    input  logic [31:0]         i_number,
    output sef_pkg::t_bcd_stat  o_stat,
    output logic [3:0]          o_digit
);
    import sef_pkg::*;

    localparam int BCD_W     = 4 * MAX_DIGITS;
    localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int BIT_CNT_W = $clog2(NUM_BITS);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_CONV = 2'd1;
    localparam logic [1:0] B_NORM = 2'd2;
    localparam logic [1:0] B_OUT  = 2'd3;

    logic [1:0]           r_state;
    logic [BCD_W-1:0]     r_bcd;
    logic [NUM_BITS-1:0]  r_bin;
    logic [BIT_CNT_W-1:0] r_bit;
    logic [CNT_W-1:0]     r_cnt;
    logic [BCD_W-1:0]     adj;
    logic [3:0]           top_digit;

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                      : r_bcd[4*d +: 4];
        end
    end

    assign top_digit     = r_bcd[BCD_W-1 -: 4];
    assign o_digit       = top_digit;
    assign o_stat.avail  = (r_state == B_OUT);
    assign o_stat.last   = (r_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (i_ctl.start) begin
                        r_state <= B_CONV;
                    end
                end
                B_CONV: begin
                    if (r_bit == BIT_CNT_W'(NUM_BITS - 1)) begin
                        r_state <= B_NORM;
                    end
                end
                B_NORM: begin
                    if (top_digit != 4'd0 || r_cnt == CNT_W'(1)) begin
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (i_ctl.take && r_cnt == CNT_W'(1)) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (i_ctl.start) begin
                    r_bin <= i_number;
                    r_bcd <= '0;
                    r_bit <= '0;
                end
            end
            B_CONV: begin
                r_bcd <= {adj[BCD_W-2:0], r_bin[NUM_BITS-1]};
                r_bin <= {r_bin[NUM_BITS-2:0], 1'b0};
                r_bit <= r_bit + BIT_CNT_W'(1);
                r_cnt <= CNT_W'(MAX_DIGITS);
            end
            B_NORM: begin
                // Drop leading zero digits one per cycle.
                if (top_digit == 4'd0 && r_cnt != CNT_W'(1)) begin
                    r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
            B_OUT: begin
                if (i_ctl.take) begin
                    r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/sse_event_text_framer_top.sv =====
// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_ready     i_kind i_number i_text_byte
//                                                  i_has_byte i_last_byte
// out       output     o_out_valid / i_out_ready   o_out_byte o_run_end
//
// One item is taken at a time; o_in_ready is high only while the sequencer is idle.
// A text item sends any prefix, its text byte, then any closing LFs.
// A retry or id item with a non-zero number starts the binary to decimal conversion and
// sends its prefix; once leading zeros are stripped it sends each digit, then one LF.
// An item that gives no bytes leaves the block ready again in the next cycle.
// Reset is synchronous and active low; a stalled output holds the sequencer.
module sse_event_text_framer_top #(
    parameter int MAX_DIGITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_number,
    input  logic [7:0]  i_text_byte,
    input  logic        i_has_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_run_end
);
    import sef_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PFX  = 3'd1;
    localparam logic [2:0] S_DIG  = 3'd2;
    localparam logic [2:0] S_BYTE = 3'd3;
    localparam logic [2:0] S_LF   = 3'd4;

    logic       r_event_open, n_event_open;
    logic       r_message_open, n_message_open;
    logic       r_line_open, n_line_open;
    logic       r_pending_cr, n_pending_cr;
    logic [2:0] r_state;
    logic [2:0] n_state;
    t_plan      r_plan;
    logic [2:0] r_idx;
    logic [1:0] r_lf;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_run_end;

    t_plan      plan;
    logic       lo, pc, closing, is_brk;
    logic [2:0] first_state, after_pfx, after_dig, after_byte;
    logic       in_fire, slot_free, emit, fire;
    logic [7:0] emit_byte;
    t_bcd_ctl   bcd_ctl;
    t_bcd_stat  bcd_stat;
    logic [3:0] bcd_digit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid & o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_end   = r_run_end;

    // Work out what the item will send and the state it leaves.
    always_comb begin
        plan           = '0;
        plan.text      = i_text_byte;
        n_event_open   = r_event_open;
        n_message_open = r_message_open;
        n_line_open    = r_line_open;
        n_pending_cr   = r_pending_cr;
        lo             = r_message_open & r_line_open;
        pc             = r_message_open & r_pending_cr;
        closing        = i_last_byte | ~i_has_byte;
        is_brk         = (i_text_byte == CR_BYTE) || (i_text_byte == LF_BYTE);
        unique case (i_kind) inside
            KIND_RETRY, KIND_ID: begin
                n_event_open   = 1'b0;
                n_message_open = 1'b0;
                n_line_open    = 1'b0;
                n_pending_cr   = 1'b0;
                if (i_number != 32'd0) begin
                    plan.prefix = (i_kind == KIND_RETRY) ? PFX_RETRY : PFX_ID;
                    plan.digits = 1'b1;
                    plan.lf_cnt = 2'd1;
                end
            end
            KIND_EVENT: begin
                n_message_open = 1'b0;
                n_line_open    = 1'b0;
                n_pending_cr   = 1'b0;
                plan.prefix    = r_event_open ? PFX_NONE : PFX_EVENT;
                plan.send_byte = i_has_byte;
                if (closing) begin
                    plan.lf_cnt  = 2'd1;
                    n_event_open = 1'b0;
                end else begin
                    n_event_open = 1'b1;
                end
            end
            KIND_MESSAGE: begin
                n_event_open = 1'b0;
                if (i_has_byte) begin
                    if (pc && i_text_byte == LF_BYTE) begin
                        // The LF of a CR LF pair has already been answered.
                        pc = 1'b0;
                    end else if (is_brk) begin
                        if (!lo) begin
                            plan.prefix = PFX_DATA;
                        end
                        plan.lf_cnt = 2'd1;
                        lo          = 1'b0;
                        pc          = (i_text_byte == CR_BYTE);
                    end else begin
                        if (!lo) begin
                            plan.prefix = PFX_DATA;
                        end
                        plan.send_byte = 1'b1;
                        lo             = 1'b1;
                        pc             = 1'b0;
                    end
                end
                if (closing) begin
                    if (lo) begin
                        plan.lf_cnt = plan.lf_cnt + 2'd1;
                    end else if (!r_message_open && !i_has_byte) begin
                        plan.prefix = PFX_DATA;
                        plan.lf_cnt = plan.lf_cnt + 2'd1;
                    end
                    plan.lf_cnt    = plan.lf_cnt + 2'd1;
                    n_message_open = 1'b0;
                    n_line_open    = 1'b0;
                    n_pending_cr   = 1'b0;
                end else begin
                    n_message_open = 1'b1;
                    n_line_open    = lo;
                    n_pending_cr   = pc;
                end
            end
            default: ;
        endcase

        if (plan.prefix != PFX_NONE) begin
            first_state = S_PFX;
        end else if (plan.digits) begin
            first_state = S_DIG;
        end else if (plan.send_byte) begin
            first_state = S_BYTE;
        end else if (plan.lf_cnt != 2'd0) begin
            first_state = S_LF;
        end else begin
            first_state = S_IDLE;
        end
    end

    always_comb begin
        after_byte = (r_lf != 2'd0) ? S_LF : S_IDLE;
        after_dig  = r_plan.send_byte ? S_BYTE : after_byte;
        if (r_plan.digits) begin
            after_pfx = S_DIG;
        end else if (r_plan.send_byte) begin
            after_pfx = S_BYTE;
        end else begin
            after_pfx = after_byte;
        end
    end

    // Byte sequencer: prefix characters, digits, text byte, closing LFs.
    always_comb begin
        slot_free = ~r_out_valid | i_out_ready;
        emit      = 1'b0;
        emit_byte = LF_BYTE;
        n_state   = r_state;
        unique case (r_state)
            S_IDLE: ;
            S_PFX: begin
                emit      = 1'b1;
                emit_byte = prefix_char(r_plan.prefix, r_idx);
                if (r_idx == prefix_len(r_plan.prefix) - 3'd1) begin
                    n_state = after_pfx;
                end
            end
            S_DIG: begin
                emit      = bcd_stat.avail;
                emit_byte = {ASCII_DIGIT_HI, bcd_digit};
                if (bcd_stat.last) begin
                    n_state = after_dig;
                end
            end
            S_BYTE: begin
                emit      = 1'b1;
                emit_byte = r_plan.text;
                n_state   = after_byte;
            end
            S_LF: begin
                emit      = 1'b1;
                emit_byte = LF_BYTE;
                if (r_lf == 2'd1) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        fire = emit & slot_free;
    end

    assign bcd_ctl.start = in_fire & plan.digits;
    assign bcd_ctl.take  = fire & (r_state == S_DIG);

    sef_bcd_unit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (bcd_ctl),
        .i_number (i_number),
        .o_stat   (bcd_stat),
        .o_digit  (bcd_digit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_event_open   <= 1'b0;
            r_message_open <= 1'b0;
            r_line_open    <= 1'b0;
            r_pending_cr   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state        <= first_state;
                r_event_open   <= n_event_open;
                r_message_open <= n_message_open;
                r_line_open    <= n_line_open;
                r_pending_cr   <= n_pending_cr;
            end else if (fire) begin
                r_state <= n_state;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_plan <= plan;
            r_lf   <= plan.lf_cnt;
            r_idx  <= '0;
        end else if (fire) begin
            r_idx <= (n_state == r_state) ? r_idx + 3'd1 : 3'd0;
            if (r_state == S_LF) begin
                r_lf <= r_lf - 2'd1;
            end
        end
        if (fire) begin
            r_out_byte <= emit_byte;
            r_run_end  <= (n_state == S_IDLE);
        end
    end

endmodule
